@@ hdl/cpr_pkg.sv @@
// Package for the clock page replacement unit.
// Holds the saturation limit of the fault counter; no dependencies.
package cpr_pkg;
  localparam int unsigned FaultMax = 32'hFFFF_FFFF;
endpackage

@@ hdl/cpr_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module cpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/clock_page_replacement_unit.sv @@
// Top level of the clock page replacement unit.
// Uses cpr_pkg and one cpr_ram for the frame page numbers.
//
// channel | dir | handshake         | payload
// req     | in  | req_valid/ready   | page_i, last_in_run_i
// rsp     | out | rsp_valid/ready   | hit_o, frame_o, evicted_*_o, fault_count_o, run_end_o
// cfg     | in  | cfg_we_i          | cfg_data_i (frames_in_use)
//
// A request is scanned for a hit over the N active frames (one RAM read per frame,
// each compare in the cycle after its read), then on a fault the hand sweeps and
// the old page is read and the new one written, then the response is posted. The
// single RAM read port makes the hit scan read the frames one after another.
// Reset clears valid and reference bits, the hand and the counter at once.
// A response waits in its register; the next request is taken once it is gone.
module clock_page_replacement_unit #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_data_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [19:0]          page_i,
  input  logic                 last_in_run_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic                 hit_o,
  output logic [3:0]           frame_o,
  output logic                 evicted_valid_o,
  output logic [19:0]          evicted_page_o,
  output logic [31:0]          fault_count_o,
  output logic                 run_end_o
);
  localparam int unsigned IdxW = FRAMES > 1 ? $clog2(FRAMES) : 1;
  localparam int unsigned CntW = $clog2(FRAMES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SWEEP, S_EVICT, S_DONE
  } state_e;

  state_e                state_q;
  logic [4:0]            fiu_q;
  logic [FRAMES-1:0]     valid_q, refb_q;
  logic [IdxW-1:0]       hand_q, idx_q, ridx_q;
  logic [31:0]           faults_q;
  logic [PAGE_BITS-1:0]  page_q, rdata;
  logic                  last_q, rd_pend_q, hit_q, evv_q;
  logic [IdxW-1:0]       frame_q;
  logic [PAGE_BITS-1:0]  evp_q;
  logic [CntW-1:0]       n_act;
  logic                  we;
  logic [IdxW-1:0]       raddr;

  always_comb begin
    if (fiu_q == 5'd0) n_act = CntW'(1);
    else if (32'(fiu_q) > FRAMES) n_act = CntW'(FRAMES);
    else n_act = CntW'(fiu_q);
  end

  function automatic logic [IdxW-1:0] wrap_inc(logic [IdxW-1:0] v, logic [CntW-1:0] n);
    logic [CntW:0] s;
    s = (CntW+1)'(v) + 1'b1;
    return (s >= (CntW+1)'(n)) ? '0 : IdxW'(s);
  endfunction

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_o;
  assign we          = (state_q == S_EVICT) && rd_pend_q;
  assign raddr       = idx_q;

  cpr_ram #(.Width(PAGE_BITS), .Depth(FRAMES)) u_pages (
    .clk_i, .we_i(we), .waddr_i(ridx_q), .wdata_i(page_q),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign frame_o        = 4'(frame_q);
  assign evicted_page_o = 20'(evp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fiu_q <= 5'd16; valid_q <= '0; refb_q <= '0;
      hand_q <= '0; faults_q <= '0; rsp_valid_o <= 1'b0; rd_pend_q <= 1'b0;
      idx_q <= '0; ridx_q <= '0;
    end else begin
      if (cfg_we_i) fiu_q <= cfg_data_i;
      if (rsp_valid_o && rsp_ready_i) rsp_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            page_q <= PAGE_BITS'(page_i); last_q <= last_in_run_i;
            idx_q <= '0; rd_pend_q <= 1'b0; state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read of idx_q issued this cycle; compare previous read
          rd_pend_q <= 1'b1; ridx_q <= idx_q;
          if (rd_pend_q && valid_q[ridx_q] && rdata == page_q) begin
            hit_q <= 1'b1; frame_q <= ridx_q; evv_q <= 1'b0; evp_q <= '0;
            refb_q[ridx_q] <= 1'b1; state_q <= S_DONE;
          end else if (rd_pend_q && (CntW+1)'(ridx_q) + 1'b1 >= (CntW+1)'(n_act)) begin
            hit_q <= 1'b0;
            if (faults_q != cpr_pkg::FaultMax) faults_q <= faults_q + 1'b1;
            if ((CntW+1)'(hand_q) >= (CntW+1)'(n_act)) hand_q <= '0;
            state_q <= S_SWEEP;
          end else if ((CntW+1)'(idx_q) + 1'b1 < (CntW+1)'(n_act)) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SWEEP: begin
          if (refb_q[hand_q]) begin
            refb_q[hand_q] <= 1'b0; hand_q <= wrap_inc(hand_q, n_act);
          end else begin
            idx_q <= hand_q; ridx_q <= hand_q; state_q <= S_EVICT;
            rd_pend_q <= 1'b0;
          end
        end
        S_EVICT: begin
          // the old page is read first, write waits for the old value
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            frame_q <= ridx_q; evv_q <= valid_q[ridx_q];
            evp_q <= valid_q[ridx_q] ? rdata : '0;
            valid_q[ridx_q] <= 1'b1; refb_q[ridx_q] <= 1'b1;
            hand_q <= wrap_inc(ridx_q, n_act); state_q <= S_DONE;
          end
        end
        S_DONE: begin
          rsp_valid_o <= 1'b1; hit_o <= hit_q; evicted_valid_o <= evv_q;
          fault_count_o <= faults_q; run_end_o <= last_q;
          if (last_q) begin
            valid_q <= '0; refb_q <= '0; hand_q <= '0; faults_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/cpr_checker.sv @@
// Port-level checker for the clock page replacement unit.
// Bound to clock_page_replacement_unit; no package use.
module cpr_checker (
  input logic        clk_i, rst_ni, req_valid_i, req_ready_o,
  input logic        rsp_valid_o, rsp_ready_i, hit_o, evicted_valid_o,
  input logic [31:0] fault_count_o
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o) else $error("response dropped");
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("ready while response pending");
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && hit_o |-> !evicted_valid_o) else $error("evict on hit");
  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !hit_o |-> fault_count_o != 32'd0) else $error("fault not counted");
endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
  .hit_o, .evicted_valid_o, .fault_count_o
);
